>>> design/docs_pkg.sv
// ----------------------------------------------------------------------------
// docs_pkg
// Shared types and constants of the delayed output channel scheduler.
// ----------------------------------------------------------------------------
package docs_pkg;

    localparam int CHANNELS         = 33;
    localparam int DIMMER_CHANNELS  = 4;
    localparam int IDX_W            = $clog2(CHANNELS);
    localparam int CNT_W            = $clog2(CHANNELS + 1);

    localparam int MAX_DELAY        = 3600;
    localparam int RELAY_ON_LEVEL   = 100;
    localparam int ALL_CHANNELS     = 255;
    localparam int RESET_DIVIDE     = 100;

    localparam int RELAY_TABLE_SIZE = 29;
    localparam int RELAY_IW         = $clog2(RELAY_TABLE_SIZE);

    // Relay register address per relay channel (channel index minus dimmers)
    localparam logic [5:0] RELAY_MAP [RELAY_TABLE_SIZE] = '{
        6'd57, 6'd56, 6'd55, 6'd54,
        6'd53, 6'd52, 6'd51, 6'd50, 6'd49, 6'd48, 6'd47, 6'd46, 6'd45, 6'd44,
        6'd43, 6'd42, 6'd41, 6'd40,
        6'd39, 6'd38, 6'd37, 6'd36, 6'd35,
        6'd34, 6'd33, 6'd32, 6'd31, 6'd30, 6'd29
    };

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_READ   = 2'd1,
        KIND_DIMMER = 2'd2,
        KIND_RELAY  = 2'd3
    } t_kind;

    typedef enum logic {
        ST_OK          = 1'b0,
        ST_BAD_CHANNEL = 1'b1
    } t_status;

    // One channel entry as held in the channel memory
    typedef struct packed {
        logic [7:0]  level;
        logic [11:0] delay;
        logic        pending;
    } t_entry;

    // One result without its last flag
    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [5:0]  channel_index;
        logic [7:0]  out_level;
        logic [5:0]  relay_address;
        logic        relay_on;
    } t_result;

endpackage

>>> design/docs_cmd_if.sv
// ----------------------------------------------------------------------------
// docs_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface docs_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  channel;
    logic [7:0]  level;
    logic [15:0] delay_seconds;

    modport source (output valid, cmd, channel, level, delay_seconds, input ready);
    modport sink   (input valid, cmd, channel, level, delay_seconds, output ready);
endinterface

>>> design/docs_res_if.sv
// ----------------------------------------------------------------------------
// docs_res_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface docs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        status;
    logic [5:0]  channel_index;
    logic [7:0]  out_level;
    logic [5:0]  relay_address;
    logic        relay_on;
    logic        last;

    modport source (output valid, kind, status, channel_index, out_level,
                    relay_address, relay_on, last, input ready);
    modport sink   (input valid, kind, status, channel_index, out_level,
                    relay_address, relay_on, last, output ready);
endinterface

>>> design/delayed_output_channel_scheduler.sv
// ----------------------------------------------------------------------------
// delayed_output_channel_scheduler
// Per-channel level/delay store with a prescaled one-second countdown sweep.
// ----------------------------------------------------------------------------
// Commands arrive one at a time on i_cmd_if and each transfer yields zero or
// more results on o_res_if, the final one flagged with last. A write to all
// channels sweeps the channel memory once. A tick that passes the prescaler
// walks every channel entry through the memory's read-modify-write pipeline,
// one entry per cycle except while a result waits for the sink to raise
// ready. Ticks stopped by the prescaler only advance it and yield no result.
// The sweep's pace is set by the single read and single write port of the
// channel memory. A new command may be taken while the last result still
// waits in the output register.
// tick_divide must be written through i_cfg_we/i_cfg_wdata only while idle;
// the block itself does not enforce this. Zero acts as one. After reset the
// first tick fires unless tick_divide is first set above RESET_DIVIDE + 1.
// ----------------------------------------------------------------------------
module delayed_output_channel_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    docs_cmd_if.sink    i_cmd_if,
    docs_res_if.source  o_res_if
);
    import docs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDWAIT = 5'b00010,
        S_WALL   = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_DRAIN  = 5'b10000
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [15:0]       r_div;
    logic [15:0]       r_presc, n_presc;
    logic [CNT_W-1:0]  r_idx, n_idx;        // sweep read pointer
    logic              r_b_valid, n_b_valid; // entry in read-back stage
    logic [IDX_W-1:0]  r_b_idx, n_b_idx;
    logic [7:0]        r_lvl;               // latched write payload
    logic [11:0]       r_dly;

    // Held result: emitted only once it is known whether another follows
    logic              r_hold_valid, n_hold_valid;
    t_result           r_hold, n_hold;

    // Output register
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic              r_out_last, n_out_last;

    // Channel memory with registered read data; valid bits cover reset
    t_entry            r_mem [CHANNELS];
    t_entry            r_q;
    logic              r_q_valid;
    logic [CHANNELS-1:0] r_valid;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    t_cmd              in_cmd;
    logic              in_xfer;
    logic              ch_all;
    logic              ch_good;
    logic [IDX_W-1:0]  ch_idx;
    logic [11:0]       in_dly;
    logic [16:0]       presc_inc;
    logic              presc_fire;

    assign in_cmd     = t_cmd'(i_cmd_if.cmd);
    assign i_cmd_if.ready = (r_state == S_IDLE);
    assign in_xfer    = i_cmd_if.valid && i_cmd_if.ready;
    assign ch_all     = (i_cmd_if.channel == 8'(ALL_CHANNELS));
    assign ch_good    = (i_cmd_if.channel != 8'd0) && (i_cmd_if.channel <= 8'(CHANNELS));
    assign ch_idx     = IDX_W'(i_cmd_if.channel - 8'd1);
    // over-long delays collapse to zero
    assign in_dly     = (i_cmd_if.delay_seconds > 16'(MAX_DELAY)) ? 12'd0
                                                                  : i_cmd_if.delay_seconds[11:0];
    assign presc_inc  = {1'b0, r_presc} + 17'd1;
    assign presc_fire = (presc_inc >= {1'b0, r_div});

    // ------------------------------------------------------------------
    // Read-back stage of the tick sweep
    // ------------------------------------------------------------------
    t_entry            b_ent;
    logic              b_dec;
    logic              b_apply;
    logic              b_emit;
    t_result           b_res;
    logic [IDX_W-1:0]  b_rel;
    logic [7:0]        b_rel_w;
    logic              can_push;
    logic              stall;
    logic              advance;
    logic              sweep_rd;

    assign b_ent   = r_q_valid ? r_q : '0;
    assign b_dec   = r_b_valid && b_ent.pending && (b_ent.delay != 12'd0);
    assign b_apply = r_b_valid && b_ent.pending && (b_ent.delay == 12'd0);
    assign b_rel   = IDX_W'(r_b_idx - IDX_W'(DIMMER_CHANNELS));
    assign b_rel_w = 8'(b_rel);

    always_comb begin
        b_res  = '0;
        b_emit = 1'b0;
        if (int'(r_b_idx) < DIMMER_CHANNELS) begin
            b_res.kind          = KIND_DIMMER;
            b_res.channel_index = 6'(r_b_idx);
            b_res.out_level     = b_ent.level;
            b_emit              = b_apply;
        end else begin
            b_res.kind          = KIND_RELAY;
            b_res.channel_index = 6'(r_b_idx);
            b_res.relay_address = RELAY_MAP[b_rel_w[RELAY_IW-1:0]];
            b_res.relay_on      = (b_ent.level == 8'(RELAY_ON_LEVEL));
            // relay levels other than off/on and channels past the map stay silent
            b_emit = b_apply && (int'(b_rel_w) < RELAY_TABLE_SIZE)
                     && ((b_ent.level == 8'(RELAY_ON_LEVEL)) || (b_ent.level == 8'd0));
        end
    end

    assign can_push = !r_out_valid || o_res_if.ready;
    // hold is full and the output register cannot take it yet
    assign stall    = (r_state == S_SWEEP) && b_emit && r_hold_valid && !can_push;
    assign advance  = !stall;
    assign sweep_rd = (r_state == S_SWEEP) && advance && (r_idx < CNT_W'(CHANNELS));

    // ------------------------------------------------------------------
    // Memory port selection
    // ------------------------------------------------------------------
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    t_entry            mem_wd;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_ra;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_b_idx;
        mem_wd = b_ent;
        mem_re = 1'b0;
        mem_ra = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                mem_wa       = ch_idx;
                mem_wd.level = i_cmd_if.level;
                mem_wd.delay = in_dly;
                mem_wd.pending = 1'b1;
                mem_we = in_xfer && (in_cmd == CMD_WRITE) && !ch_all && ch_good;
                mem_ra = ch_idx;
                mem_re = in_xfer && (in_cmd == CMD_READ) && ch_good;
            end
            S_WALL: begin
                mem_we       = 1'b1;
                mem_wa       = r_idx[IDX_W-1:0];
                mem_wd.level = r_lvl;
                mem_wd.delay = r_dly;
                mem_wd.pending = 1'b1;
            end
            S_SWEEP: begin
                mem_re = sweep_rd;
                mem_we = advance && (b_dec || b_apply);
                if (b_dec) begin
                    mem_wd.delay = b_ent.delay - 12'd1;
                end else begin
                    mem_wd.pending = 1'b0;
                end
            end
            S_RDWAIT, S_DRAIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_q       <= r_mem[mem_ra];
            r_q_valid <= r_valid[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[mem_wa] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_presc      = r_presc;
        n_idx        = r_idx;
        n_b_valid    = r_b_valid;
        n_b_idx      = r_b_idx;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !o_res_if.ready;
        n_out        = r_out;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_hold = '0;
                    unique case (in_cmd)
                        CMD_TICK: begin
                            if (presc_fire) begin
                                n_presc   = '0;
                                n_idx     = '0;
                                n_b_valid = 1'b0;
                                n_state   = S_SWEEP;
                            end else begin
                                n_presc   = presc_inc[15:0];
                            end
                        end
                        CMD_WRITE: begin
                            n_hold.kind = KIND_ACK;
                            if (ch_all) begin
                                n_idx   = '0;
                                n_state = S_WALL;
                            end else begin
                                n_hold_valid = 1'b1;
                                n_state      = S_DRAIN;
                                if (ch_good) begin
                                    n_hold.channel_index = 6'(ch_idx);
                                end else begin
                                    n_hold.status = ST_BAD_CHANNEL;
                                end
                            end
                        end
                        CMD_READ: begin
                            n_hold.kind = KIND_READ;
                            if (ch_good) begin
                                n_hold.channel_index = 6'(ch_idx);
                                n_state = S_RDWAIT;
                            end else begin
                                n_hold.status = ST_BAD_CHANNEL;
                                n_hold_valid  = 1'b1;
                                n_state       = S_DRAIN;
                            end
                        end
                        CMD_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_hold.out_level = r_q_valid ? r_q.level : 8'd0;
                n_hold_valid     = 1'b1;
                n_state          = S_DRAIN;
            end
            S_WALL: begin
                n_idx = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(CHANNELS - 1)) begin
                    n_hold_valid = 1'b1;
                    n_state      = S_DRAIN;
                end
            end
            S_SWEEP: begin
                if (advance) begin
                    if (b_emit) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_hold;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold       = b_res;
                    end
                    n_b_valid = sweep_rd;
                    n_b_idx   = r_idx[IDX_W-1:0];
                    if (sweep_rd) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                    if (!sweep_rd && !r_b_valid) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (can_push) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_hold;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_div        <= 16'(RESET_DIVIDE);
            r_presc      <= 16'(RESET_DIVIDE);
            r_idx        <= '0;
            r_b_valid    <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_presc      <= n_presc;
            r_idx        <= n_idx;
            r_b_valid    <= n_b_valid;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_div <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_idx    <= n_b_idx;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        if (in_xfer) begin
            r_lvl <= i_cmd_if.level;
            r_dly <= in_dly;
        end
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.kind          = r_out.kind;
    assign o_res_if.status        = r_out.status;
    assign o_res_if.channel_index = r_out.channel_index;
    assign o_res_if.out_level     = r_out.out_level;
    assign o_res_if.relay_address = r_out.relay_address;
    assign o_res_if.relay_on      = r_out.relay_on;
    assign o_res_if.last          = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No result may be left over once a command is fully done
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held result left behind in idle");

    // Sweep write-back never targets the entry being read
    a_rmw_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("read and write-back collide on one entry");

    // A stalled sweep keeps its read-back entry
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> ($stable(r_b_idx) && r_b_valid && $stable(r_idx)))
        else $error("sweep moved while stalled");

    // Sweep pointer never passes the channel count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNT_W'(CHANNELS))
        else $error("sweep pointer out of range");

endmodule
